FILE: rtl/core/gvc_pkg.sv
`default_nettype none

package gvc_pkg;

  // Field widths and fixed-point formats
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_BITS      = 24;
  localparam int GAIN_FRAC      = 16;
  localparam int ACC_BITS       = 48;
  localparam int ACC_SHIFT      = ACC_BITS - GAIN_BITS;
  localparam int TIME_BITS      = 16;
  localparam int SPM_BITS       = 16;
  localparam int SPM_FRAC       = 8;
  localparam int LOG2_BITS      = 4;
  localparam int MAX_BLOCK_LOG2 = 10;
  localparam int LEN_BITS       = 25;
  localparam int BASE_LEN_BITS  = TIME_BITS + SPM_BITS - SPM_FRAC;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  // Shared multiplier: signed operands wide enough for every use
  localparam int MUL_OP_BITS = ((SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS) + 1;
  localparam int PROD_BITS   = 2 * MUL_OP_BITS;

  // Serial divider
  localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

  // Reset values of the configuration registers
  localparam logic [TIME_BITS-1:0]        RAMP_TIME_RST  = 16'd0;
  localparam logic [SPM_BITS-1:0]         SPM_RST        = 16'd11290;
  localparam logic [LOG2_BITS-1:0]        BLOCK_LOG2_RST = 4'd6;
  localparam logic signed [GAIN_BITS-1:0] START_GAIN_RST = 24'sd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RAMP_TIME  = 2'd0,
    REG_SPM        = 2'd1,
    REG_BLOCK_LOG2 = 2'd2,
    REG_START_GAIN = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_SET_TARGET = 1'b1
  } op_t;

endpackage

`default_nettype wire

FILE: rtl/core/gvc_in_if.sv
`default_nettype none

interface gvc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic signed [gvc_pkg::SAMPLE_BITS-1:0] sample_in;
  logic signed [gvc_pkg::GAIN_BITS-1:0]   new_gain;

  modport source (output valid, operation, sample_in, new_gain, input ready);
  modport sink   (input valid, operation, sample_in, new_gain, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gvc_out_if.sv
`default_nettype none

interface gvc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gvc_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   ramping;

  modport source (output valid, sample_out, ramping, input ready);
  modport sink   (input valid, sample_out, ramping, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gain_ramp_volume_control.sv
`default_nettype none

// Volume stage with a linear gain ramp. Each audio sample item gives one scaled,
// saturated sample; a set-target item gives no result and starts a ramp from the
// current gain to the new target over floor(ramp_time_ms * samples_per_ms / 256)
// samples rounded up to the next whole block (an exact multiple gets one more
// block). One signed multiplier and a one-bit-per-cycle restoring divider do all
// the arithmetic under a small sequencer, and the input is not ready while an
// item is in work. A sample item runs accept with gain update, multiply, and
// saturate into the output register once it is free; a set-target item runs
// accept, length multiply, length round-up, 48 divider steps, slope sign and
// clamp. The output register lets the next item in while a result waits to be
// taken. Configuration is written through wr_en/wr_index/wr_data while the block
// is idle, a user rule the block does not enforce; writing start_gain also reloads the running gain.
module gain_ramp_volume_control (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [gvc_pkg::CFG_INDEX_BITS-1:0]    wr_index,
  input  logic [gvc_pkg::CFG_DATA_BITS-1:0]     wr_data,
  gvc_in_if.sink                                in_ch,
  gvc_out_if.source                             out_ch
);

  localparam int AB  = gvc_pkg::ACC_BITS;
  localparam int GB  = gvc_pkg::GAIN_BITS;
  localparam int SB  = gvc_pkg::SAMPLE_BITS;
  localparam int LB  = gvc_pkg::LEN_BITS;
  localparam int MB  = gvc_pkg::MUL_OP_BITS;
  localparam int PB  = gvc_pkg::PROD_BITS;
  localparam int PSB = PB - gvc_pkg::GAIN_FRAC;

  localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
  localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};
  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_MUL,
    ST_LEN_ADJ,
    ST_DIV,
    ST_DIV_FIN,
    ST_SMP_MUL,
    ST_SMP_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [gvc_pkg::TIME_BITS-1:0] ramp_time_ms;
  logic [gvc_pkg::SPM_BITS-1:0]  samples_per_ms;
  logic [gvc_pkg::LOG2_BITS-1:0] block_size_log2;

  // Ramp state
  logic signed [AB-1:0] gain_acc;
  logic signed [GB-1:0] target_gain;
  logic signed [AB-1:0] gain_slope;
  logic [LB-1:0]        ramp_left;

  // Work registers
  logic signed [SB-1:0]               smp;
  logic                               smp_ramping;
  logic signed [PB-1:0]               prod;
  logic [LB-1:0]                      div_len;
  logic [LB-1:0]                      div_rem;
  logic [AB-1:0]                      div_quo;
  logic                               div_neg;
  logic [gvc_pkg::DIV_CNT_BITS-1:0]   div_cnt;

  // Output register
  logic                 out_valid;
  logic signed [SB-1:0] out_sample;
  logic                 out_ramping;

  // Combinational nets
  logic signed [MB-1:0]                      mul_a;
  logic signed [MB-1:0]                      mul_b;
  logic signed [PB-1:0]                      mul_p;
  logic signed [GB-1:0]                      gain_sel;
  logic [gvc_pkg::BASE_LEN_BITS-1:0]         len_base;
  logic [gvc_pkg::LOG2_BITS-1:0]             blk_log;
  logic [LB-1:0]                             blk;
  logic [LB-1:0]                             len_next;
  logic [AB:0]                               diff;
  logic [AB:0]                               diff_abs;
  logic [LB:0]                               div_trial;
  logic                                      div_ge;
  logic [LB-1:0]                             div_rem_next;
  logic signed [AB-1:0]                      slope_next;
  logic signed [AB:0]                        acc_sum;
  logic signed [AB-1:0]                      acc_next;
  logic signed [PSB-1:0]                     prod_shift;
  logic [PSB-SB:0]                           prod_hi;
  logic signed [SB-1:0]                      sample_sat;
  logic                                      in_accept;

  assign in_ch.ready       = (state == ST_IDLE);
  assign in_accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.ramping    = out_ramping;

  // Select gain for the product: ramping gain or target
  assign gain_sel = smp_ramping ? gain_acc[AB-1 -: GB] : target_gain;

  // Share one multiplier between ramp length and sample scaling
  always_comb begin
    if (state == ST_SMP_MUL) begin
      mul_a = MB'(smp);
      mul_b = MB'(gain_sel);
    end else begin
      mul_a = $signed({{(MB-gvc_pkg::TIME_BITS){1'b0}}, ramp_time_ms});
      mul_b = $signed({{(MB-gvc_pkg::SPM_BITS){1'b0}}, samples_per_ms});
    end
  end

  assign mul_p = mul_a * mul_b;

  // Round ramp length up to the next whole block
  assign len_base = prod[gvc_pkg::SPM_FRAC +: gvc_pkg::BASE_LEN_BITS];
  assign blk_log  = (block_size_log2 > gvc_pkg::LOG2_BITS'(gvc_pkg::MAX_BLOCK_LOG2)) ?
                    gvc_pkg::LOG2_BITS'(gvc_pkg::MAX_BLOCK_LOG2) : block_size_log2;
  assign blk      = LB'(1) << blk_log;
  assign len_next = LB'(len_base) + blk - (LB'(len_base) & (blk - LB'(1)));

  // Distance from current gain to target, as sign and magnitude
  assign diff     = {target_gain[GB-1], target_gain, {gvc_pkg::ACC_SHIFT{1'b0}}}
                  - {gain_acc[AB-1], gain_acc};
  assign diff_abs = diff[AB] ? (~diff + (AB+1)'(1)) : diff;

  // One restoring divider step
  assign div_trial    = {div_rem, div_quo[AB-1]};
  assign div_ge       = (div_trial >= {1'b0, div_len});
  assign div_rem_next = div_ge ? LB'(div_trial - {1'b0, div_len}) : LB'(div_trial);

  // Apply sign to the quotient and clamp to the accumulator range
  always_comb begin
    if (div_neg) begin
      slope_next = div_quo[AB-1] ? ACC_MIN : -$signed(div_quo);
    end else begin
      slope_next = div_quo[AB-1] ? ACC_MAX : $signed(div_quo);
    end
  end

  // Advance the gain by the slope, saturating
  assign acc_sum  = {gain_acc[AB-1], gain_acc} + {gain_slope[AB-1], gain_slope};
  assign acc_next = (acc_sum[AB] != acc_sum[AB-1]) ? (acc_sum[AB] ? ACC_MIN : ACC_MAX)
                                                   : acc_sum[AB-1:0];

  // Drop the fraction of the product and saturate to the sample width
  assign prod_shift = prod[PB-1:gvc_pkg::GAIN_FRAC];
  assign prod_hi    = prod_shift[PSB-1:SB-1];
  assign sample_sat = ((&prod_hi) || !(|prod_hi)) ? prod_shift[SB-1:0]
                    : (prod_shift[PSB-1] ? SMP_MIN : SMP_MAX);

  // Sequencer, ramp state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ramp_time_ms    <= gvc_pkg::RAMP_TIME_RST;
      samples_per_ms  <= gvc_pkg::SPM_RST;
      block_size_log2 <= gvc_pkg::BLOCK_LOG2_RST;
      gain_acc        <= {gvc_pkg::START_GAIN_RST, {gvc_pkg::ACC_SHIFT{1'b0}}};
      target_gain     <= '0;
      gain_slope      <= '0;
      ramp_left       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (wr_en) begin
        unique case (gvc_pkg::cfg_reg_t'(wr_index))
          gvc_pkg::REG_RAMP_TIME:  ramp_time_ms    <= wr_data[gvc_pkg::TIME_BITS-1:0];
          gvc_pkg::REG_SPM:        samples_per_ms  <= wr_data[gvc_pkg::SPM_BITS-1:0];
          gvc_pkg::REG_BLOCK_LOG2: block_size_log2 <= wr_data[gvc_pkg::LOG2_BITS-1:0];
          gvc_pkg::REG_START_GAIN: begin
            gain_acc <= {wr_data[GB-1:0], {gvc_pkg::ACC_SHIFT{1'b0}}};
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_ch.operation == gvc_pkg::OP_SET_TARGET) begin
              target_gain <= in_ch.new_gain;
              state       <= ST_LEN_MUL;
            end else begin
              // Step the ramp before the sample uses the gain
              smp         <= in_ch.sample_in;
              smp_ramping <= (ramp_left != '0);
              if (ramp_left != '0) begin
                ramp_left <= ramp_left - LB'(1);
                gain_acc  <= acc_next;
              end
              state <= ST_SMP_MUL;
            end
          end
        end

        ST_LEN_MUL: begin
          prod  <= mul_p;
          state <= ST_LEN_ADJ;
        end

        ST_LEN_ADJ: begin
          ramp_left <= len_next;
          div_len   <= len_next;
          div_rem   <= '0;
          div_quo   <= diff_abs[AB-1:0];
          div_neg   <= diff[AB];
          div_cnt   <= '0;
          state     <= ST_DIV;
        end

        ST_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= {div_quo[AB-2:0], div_ge};
          div_cnt <= div_cnt + gvc_pkg::DIV_CNT_BITS'(1);
          if (div_cnt == gvc_pkg::DIV_CNT_BITS'(AB-1)) begin
            state <= ST_DIV_FIN;
          end
        end

        ST_DIV_FIN: begin
          gain_slope <= slope_next;
          state      <= ST_IDLE;
        end

        ST_SMP_MUL: begin
          prod  <= mul_p;
          state <= ST_SMP_OUT;
        end

        ST_SMP_OUT: begin
          // Hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid   <= 1'b1;
            out_sample  <= sample_sat;
            out_ramping <= smp_ramping;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int QUIET_ITEMS   = 150;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int NUM_DIR       = 34;

  localparam longint ACC_MAX = (longint'(1) <<< (gvc_pkg::ACC_BITS - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint SMP_MAX = (longint'(1) <<< (gvc_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;

  localparam logic [23:0] G_MAX = 24'h7FFFFF;
  localparam logic [23:0] G_MIN = 24'h800000;
  localparam logic [23:0] UNITY = 24'h010000;

  typedef struct packed {
    logic signed [gvc_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                   ramping;
  } scaled_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    gvc_pkg::cfg_reg_t                 idx;
    logic [gvc_pkg::CFG_DATA_BITS-1:0] data;
    gvc_pkg::op_t                      op;
    logic [gvc_pkg::SAMPLE_BITS-1:0]   smp;
    logic [gvc_pkg::GAIN_BITS-1:0]     gain;
    logic                              typed;
    logic [gvc_pkg::SAMPLE_BITS-1:0]   want_out;
    logic                              want_ramp;
  } dir_row_t;

  // Directed walk: reset state, full-scale saturation, slope clamping both ways,
  // zero ramp time, retarget mid-ramp, exact-multiple length and end of ramp
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MAX, 24'd0, 1'b1, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MIN, 24'd0, 1'b1, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, UNITY, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h400000, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_START_GAIN, G_MAX,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_BLOCK_LOG2, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_SPM, 24'h00FFFF,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, G_MAX, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MAX, 24'd0, 1'b1, G_MAX, 1'b1},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MIN, 24'd0, 1'b1, G_MIN, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, G_MIN, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MAX, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MAX, 24'd0, 1'b1, G_MIN, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, G_MIN, 24'd0, 1'b1, G_MAX, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'd0, G_MAX, 1'b1, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_START_GAIN, G_MIN,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, G_MAX, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'd1, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_RAMP_TIME, 24'd1,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_SPM, 24'd256,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_BLOCK_LOG2, 24'd2,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, UNITY, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h123456, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'hEDCBAA, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, 24'hFF0000, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_RAMP_TIME, 24'd2,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_CFG, gvc_pkg::REG_BLOCK_LOG2, 24'd1,
      gvc_pkg::OP_SAMPLE, 24'd0, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SET_TARGET, 24'd0, 24'h020000, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h7FF000, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h800123, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h000100, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h3FFFFF, 24'd0, 1'b0, 24'd0, 1'b0},
    '{ROW_ITEM, gvc_pkg::REG_RAMP_TIME, 24'd0,
      gvc_pkg::OP_SAMPLE, 24'h001000, 24'd0, 1'b1, 24'h002000, 1'b0}
  };

  logic clk;
  logic rst = 1'b1;

  logic                               wr_en    = 1'b0;
  logic [gvc_pkg::CFG_INDEX_BITS-1:0] wr_index = '0;
  logic [gvc_pkg::CFG_DATA_BITS-1:0]  wr_data  = '0;

  logic                            src_valid  = 1'b0;
  gvc_pkg::op_t                    src_op     = gvc_pkg::OP_SAMPLE;
  logic [gvc_pkg::SAMPLE_BITS-1:0] src_smp    = '0;
  logic [gvc_pkg::GAIN_BITS-1:0]   src_gain   = '0;
  logic                            sink_ready = 1'b0;
  logic                            steady_tail = 1'b0;
  int                              stall_left = 0;

  gvc_in_if  in_ch ();
  gvc_out_if out_ch ();

  assign in_ch.valid     = src_valid;
  assign in_ch.operation = src_op;
  assign in_ch.sample_in = src_smp;
  assign in_ch.new_gain  = src_gain;
  assign out_ch.ready    = sink_ready;

  gain_ramp_volume_control DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Register mirror and gain state of the volume stage
  logic [gvc_pkg::TIME_BITS-1:0]        cfg_ramp_ms  = gvc_pkg::RAMP_TIME_RST;
  logic [gvc_pkg::SPM_BITS-1:0]         cfg_spm      = gvc_pkg::SPM_RST;
  logic [gvc_pkg::LOG2_BITS-1:0]        cfg_blk_log2 = gvc_pkg::BLOCK_LOG2_RST;
  logic signed [gvc_pkg::ACC_BITS-1:0]  run_gain     =
    {gvc_pkg::START_GAIN_RST, {gvc_pkg::ACC_SHIFT{1'b0}}};
  logic signed [gvc_pkg::GAIN_BITS-1:0] tgt_gain     = '0;
  logic signed [gvc_pkg::ACC_BITS-1:0]  step_slope   = '0;
  logic [gvc_pkg::LEN_BITS-1:0]         ramp_cnt     = '0;

  scaled_t pending_scaled [$];

  int cycle_cnt    = 0;
  int items_sent   = 0;
  int targets_set  = 0;
  int checked      = 0;
  int ramp_results = 0;
  int full_scale   = 0;
  int mismatches   = 0;
  int settings_run = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [gvc_pkg::ACC_BITS-1:0] clamp_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX[gvc_pkg::ACC_BITS-1:0];
    if (v < ACC_MIN) return ACC_MIN[gvc_pkg::ACC_BITS-1:0];
    return v[gvc_pkg::ACC_BITS-1:0];
  endfunction

  // Start a ramp: length rounded up to the next whole block, slope toward the target
  function automatic void start_ramp(input logic signed [gvc_pkg::GAIN_BITS-1:0] g);
    int unsigned lg;
    longint rt_v, spm_v, base_len, blk_len, full_len, g_v, acc_v, diff;
    lg = (cfg_blk_log2 > gvc_pkg::MAX_BLOCK_LOG2) ? gvc_pkg::MAX_BLOCK_LOG2 : cfg_blk_log2;
    blk_len = longint'(1) << lg;
    rt_v = longint'(cfg_ramp_ms);
    spm_v = longint'(cfg_spm);
    base_len = (rt_v * spm_v) >> gvc_pkg::SPM_FRAC;
    full_len = base_len + blk_len - (base_len & (blk_len - 1));
    g_v = longint'(g);
    acc_v = longint'(run_gain);
    diff = (g_v <<< gvc_pkg::ACC_SHIFT) - acc_v;
    tgt_gain = g;
    step_slope = clamp_acc(diff / full_len);
    ramp_cnt = full_len[gvc_pkg::LEN_BITS-1:0];
  endfunction

  // Advance the ramp by one sample and scale the sample with saturation
  function automatic scaled_t scale_sample(
    input logic signed [gvc_pkg::SAMPLE_BITS-1:0] smp
  );
    scaled_t res;
    longint g_v, s_v, prod;
    res.ramping = (ramp_cnt != '0);
    if (res.ramping) begin
      ramp_cnt = ramp_cnt - gvc_pkg::LEN_BITS'(1);
      run_gain = clamp_acc(longint'(run_gain) + longint'(step_slope));
      g_v = longint'(run_gain) >>> gvc_pkg::ACC_SHIFT;
    end else begin
      g_v = longint'(tgt_gain);
    end
    s_v = longint'(smp);
    prod = (s_v * g_v) >>> gvc_pkg::GAIN_FRAC;
    if (prod > SMP_MAX) prod = SMP_MAX;
    else if (prod < SMP_MIN) prod = SMP_MIN;
    res.sample_out = prod[gvc_pkg::SAMPLE_BITS-1:0];
    return res;
  endfunction

  function automatic logic [gvc_pkg::GAIN_BITS-1:0] pick_gain();
    int v;
    case ($urandom_range(0, 9))
      0: v = int'(G_MAX);
      1: v = -8388608;
      2: v = 0;
      3, 4, 5: v = int'($urandom_range(0, 262143)) - 131072;
      default: v = $urandom;
    endcase
    return v[gvc_pkg::GAIN_BITS-1:0];
  endfunction

  function automatic logic [gvc_pkg::SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = int'(G_MAX);
      1: v = -8388608;
      2, 3: v = int'($urandom_range(0, 8191)) - 4096;
      default: v = $urandom;
    endcase
    return v[gvc_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Drop valid and hold until every result is out and a set-target would be done
  task automatic wait_idle();
    @(negedge clk);
    src_valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input gvc_pkg::cfg_reg_t idx,
                           input logic [gvc_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      gvc_pkg::REG_RAMP_TIME:  cfg_ramp_ms = data[gvc_pkg::TIME_BITS-1:0];
      gvc_pkg::REG_SPM:        cfg_spm = data[gvc_pkg::SPM_BITS-1:0];
      gvc_pkg::REG_BLOCK_LOG2: cfg_blk_log2 = data[gvc_pkg::LOG2_BITS-1:0];
      gvc_pkg::REG_START_GAIN:
        run_gain = {data[gvc_pkg::GAIN_BITS-1:0], {gvc_pkg::ACC_SHIFT{1'b0}}};
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Offer one item, hold it until taken, then record what it should produce
  task automatic send_item(input gvc_pkg::op_t op,
                           input logic [gvc_pkg::SAMPLE_BITS-1:0] smp,
                           input logic [gvc_pkg::GAIN_BITS-1:0] gain, input logic typed,
                           input logic [gvc_pkg::SAMPLE_BITS-1:0] want_out,
                           input logic want_ramp);
    scaled_t res;
    int gap;
    if (!steady_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      src_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_op    <= op;
    src_smp   <= smp;
    src_gain  <= gain;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (op == gvc_pkg::OP_SET_TARGET) begin
      start_ramp(gain);
      targets_set++;
    end else begin
      res = scale_sample(smp);
      if (typed) begin
        res.sample_out = want_out;
        res.ramping = want_ramp;
      end
      pending_scaled.push_back(res);
    end
  endtask

  task automatic send_target();
    send_item(gvc_pkg::OP_SET_TARGET, pick_sample(), pick_gain(), 1'b0, '0, 1'b0);
  endtask

  task automatic send_sample();
    send_item(gvc_pkg::OP_SAMPLE, pick_sample(), pick_gain(), 1'b0, '0, 1'b0);
  endtask

  // New register setting for each phase, with junk in the unused data bits
  task automatic configure_phase(input int p);
    logic [31:0] noise;
    int unsigned rt;
    int unsigned spm;
    int unsigned lg;
    wait_idle();
    noise = $urandom;
    case (p % 6)
      0: begin
        rt = 0;
        spm = $urandom_range(1, 65535);
        lg = $urandom_range(0, 6);
      end
      1: begin
        rt = $urandom_range(1, 8);
        spm = $urandom_range(1, 4096);
        lg = $urandom_range(0, 4);
      end
      2: begin
        rt = $urandom_range(1, 4);
        spm = 65535;
        lg = $urandom_range(gvc_pkg::MAX_BLOCK_LOG2 + 1, 15);
      end
      3: begin
        rt = 65535;
        spm = 1;
        lg = $urandom_range(0, 8);
      end
      4: begin
        rt = $urandom_range(0, 3);
        spm = $urandom_range(128, 1024);
        lg = 0;
      end
      default: begin
        rt = 65535;
        spm = 65535;
        lg = gvc_pkg::MAX_BLOCK_LOG2;
      end
    endcase
    write_reg(gvc_pkg::REG_RAMP_TIME, {noise[7:0], rt[gvc_pkg::TIME_BITS-1:0]});
    write_reg(gvc_pkg::REG_SPM, {noise[15:8], spm[gvc_pkg::SPM_BITS-1:0]});
    write_reg(gvc_pkg::REG_BLOCK_LOG2, {noise[31:12], lg[gvc_pkg::LOG2_BITS-1:0]});
    write_reg(gvc_pkg::REG_START_GAIN, pick_gain());
    settings_run++;
  endtask

  // Receiver: random stall bursts, none in the closing stretch
  always @(negedge clk) begin
    if (steady_tail) begin
      sink_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 17);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest expected one
  always @(posedge clk) begin
    scaled_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_scaled.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: sample_out %0d ramping %0b",
                   $signed(out_ch.sample_out), out_ch.ramping);
      end else begin
        want = pending_scaled.pop_front();
        checked++;
        if (want.ramping) ramp_results++;
        if (want.sample_out == G_MAX || want.sample_out == G_MIN) full_scale++;
        if (out_ch.sample_out !== want.sample_out || out_ch.ramping !== want.ramping) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at result %0d: expected sample_out %0d ramping %0b, got %0d %0b",
                     checked, $signed(want.sample_out), want.ramping,
                     $signed(out_ch.sample_out), out_ch.ramping);
        end
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_scaled.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int rand_start;
    int phase;
    int phase_start;
    int n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        if (i == 0 || DIR_ROWS[i-1].kind != ROW_CFG) wait_idle();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
      end else begin
        send_item(DIR_ROWS[i].op, DIR_ROWS[i].smp, DIR_ROWS[i].gain, DIR_ROWS[i].typed,
                  DIR_ROWS[i].want_out, DIR_ROWS[i].want_ramp);
      end
    end

    // Random phases: mostly set-target followed by a run of samples
    rand_start = items_sent;
    phase = 0;
    configure_phase(phase);
    phase_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      steady_tail = (items_sent - rand_start >= RANDOM_ITEMS - QUIET_ITEMS);
      if (!steady_tail && items_sent - phase_start >= PHASE_ITEMS) begin
        phase++;
        configure_phase(phase);
        phase_start = items_sent;
      end
      case ($urandom_range(0, 9))
        7: repeat ($urandom_range(1, 20)) send_sample();
        8: begin
          send_target();
          send_target();
          repeat ($urandom_range(1, 40)) send_sample();
        end
        9: if (!steady_tail) wait_idle();
        default: begin
          send_target();
          n = (ramp_cnt > 157) ? 160 : int'(ramp_cnt) + 3;
          repeat ($urandom_range(1, n)) send_sample();
        end
      endcase
    end

    // Drain and let any trailing work settle
    @(negedge clk);
    src_valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d gain changes) over %0d register settings",
             items_sent, targets_set, settings_run);
    $display("Checked %0d scaled samples: %0d on a ramp, %0d at full scale, %0d mismatches",
             checked, ramp_results, full_scale, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
